>>> rtl/core/tspg_pkg.sv
// Shared types and constants for the trapezoid step profile generator.
// No dependencies.
package tspg_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_EXEC  = 2'd1,
    MODE_SYNC  = 2'd2,
    MODE_ERROR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_LOAD   = 2'd1,
    FUNC_SETPOS = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_PROF = 2'd1,
    ST_DIV  = 2'd2,
    ST_RESP = 2'd3
  } state_e;

  localparam logic [1:0] CFG_CLOCK_HZ  = 2'd0;
  localparam logic [1:0] CFG_MIN_RATE  = 2'd1;
  localparam logic [1:0] CFG_ACC_TICK  = 2'd2;

  localparam logic [26:0] CLOCK_HZ_RST = 27'd48000000;
  localparam logic [19:0] MIN_RATE_RST = 20'd800;
  localparam logic [31:0] ACC_TICK_RST = 32'd960000;
  // clock * 60 over the reset rate floor
  localparam logic [31:0] PERIOD_RST   = 32'd3600000;
  localparam logic [31:0] LOAD_PERIOD  = 32'd100;

  localparam int unsigned DIV_STEPS = 33;

  typedef struct packed {
    logic accept;
    logic prof;
    logic div_start;
    logic period_wr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_prof;
    logic need_div;
    logic prof_set;
    logic div_done;
  } ctrl_sts_t;

endpackage

>>> rtl/core/trapezoid_step_profile_generator.sv
// Trapezoid step profile generator, top level: controller, datapath, divider.
// Sequence from accept to result valid: status items and ticks with no profile update go
// straight to the response state, a tick with no rate change passes the profile state, a
// load runs the 33-step period divider, and a tick whose rate change passes the profile
// state and then the divider. One transaction at a time; the divider path sets the worst.
// Reset: asynchronous active low; idle mode, period at clock*60 over the rate floor.
module trapezoid_step_profile_generator
  import tspg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] move_length_i,
  input  logic [30:0] move_events_i,
  input  logic [31:0] start_rate_i,
  input  logic [31:0] cruise_rate_i,
  input  logic [31:0] end_rate_i,
  input  logic [29:0] rate_delta_i,
  input  logic [30:0] accel_end_mark_i,
  input  logic [30:0] decel_start_mark_i,
  input  logic [31:0] position_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        step_pulse_o,
  output logic        step_dir_o,
  output logic [31:0] timer_period_o,
  output logic        timer_run_o,
  output logic        sync_request_o,
  output logic        block_done_o,
  output logic [1:0]  mode_o,
  output logic [31:0] motor_position_o
);

  ctrl_cmd_t   cmd;
  ctrl_sts_t   sts;
  logic        div_start, div_done;
  logic [32:0] dividend, quotient;
  logic [31:0] divisor;

  assign div_start = cmd.div_start;

  // Sequence each transaction: accept, optional profile update, optional divide.
  tspg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold motion state and compute the Bresenham and profile updates.
  tspg_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .div_done_i         (div_done),
    .quotient_i         (quotient),
    .dividend_o         (dividend),
    .divisor_o          (divisor),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .func_i             (func_i),
    .move_length_i      (move_length_i),
    .move_events_i      (move_events_i),
    .start_rate_i       (start_rate_i),
    .cruise_rate_i      (cruise_rate_i),
    .end_rate_i         (end_rate_i),
    .rate_delta_i       (rate_delta_i),
    .accel_end_mark_i   (accel_end_mark_i),
    .decel_start_mark_i (decel_start_mark_i),
    .position_value_i   (position_value_i),
    .step_pulse_o       (step_pulse_o),
    .step_dir_o         (step_dir_o),
    .timer_period_o     (timer_period_o),
    .timer_run_o        (timer_run_o),
    .sync_request_o     (sync_request_o),
    .block_done_o       (block_done_o),
    .mode_o             (mode_o),
    .motor_position_o   (motor_position_o)
  );

  // Convert a new rate to a timer period, one quotient bit a cycle.
  tspg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

endmodule

>>> rtl/core/tspg_div.sv
// Restoring divider, one quotient bit per cycle, 33-bit dividend.
// Depends on tspg_pkg.
module tspg_div
  import tspg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [32:0] quotient_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [31:0] rem_q, dvs_q;
  logic [32:0] quo_q;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  assign trial = {rem_q, quo_q[32]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      quo_q <= {quo_q[31:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/core/tspg_ctrl.sv
// Sequencing state machine: accept, profile update, period divide, respond.
// Depends on tspg_pkg.
module tspg_ctrl
  import tspg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.need_prof) begin
            state_d = ST_PROF;
          end else if (sts_i.need_div) begin
            cmd_o.div_start = 1'b1;
            state_d = ST_DIV;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_PROF: begin
        cmd_o.prof = 1'b1;
        if (sts_i.prof_set) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.period_wr = 1'b1;
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/tspg_dp.sv
// Datapath: motion state, block registers, Bresenham and profile arithmetic.
// Depends on tspg_pkg; divider operands go out, the quotient comes back.
module tspg_dp
  import tspg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_cmd_t   cmd_i,
  output ctrl_sts_t   sts_o,
  input  logic        div_done_i,
  input  logic [32:0] quotient_i,
  output logic [32:0] dividend_o,
  output logic [31:0] divisor_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic [1:0]  func_i,
  input  logic [31:0] move_length_i,
  input  logic [30:0] move_events_i,
  input  logic [31:0] start_rate_i,
  input  logic [31:0] cruise_rate_i,
  input  logic [31:0] end_rate_i,
  input  logic [29:0] rate_delta_i,
  input  logic [30:0] accel_end_mark_i,
  input  logic [30:0] decel_start_mark_i,
  input  logic [31:0] position_value_i,
  output logic        step_pulse_o,
  output logic        step_dir_o,
  output logic [31:0] timer_period_o,
  output logic        timer_run_o,
  output logic        sync_request_o,
  output logic        block_done_o,
  output logic [1:0]  mode_o,
  output logic [31:0] motor_position_o
);

  logic [26:0] clk_hz_q;
  logic [19:0] min_rate_q;
  logic [31:0] acc_tick_q;

  mode_e       mode_q;
  logic [33:0] bres_q;
  logic [30:0] ev_done_q;
  logic [31:0] rate_q, period_q, safe_q, pos_q;
  logic [32:0] tick_q;
  logic        pend_step_q, pend_dir_q;

  logic [31:0] blk_len_q, blk_cruise_q, blk_end_q;
  logic [30:0] blk_events_q, blk_acc_q, blk_dec_q;
  logic [29:0] blk_delta_q;

  logic pulse_q, dir_q, run_q, sync_q, done_q, load_q;

  func_e func;
  assign func = func_e'(func_i);

  // Bresenham event
  logic [31:0] mag;
  logic [33:0] bres_sum, bres_next;
  logic        bres_hit;
  logic [30:0] ev_inc;
  logic        blk_last;

  assign mag       = blk_len_q[31] ? (~blk_len_q + 32'd1) : blk_len_q;
  assign bres_sum  = bres_q + {2'b00, mag};
  assign bres_hit  = (bres_sum != '0) && !bres_sum[33];
  assign bres_next = bres_hit ? bres_sum - {3'b000, blk_events_q} : bres_sum;
  assign ev_inc    = ev_done_q + 31'd1;
  assign blk_last  = blk_events_q <= ev_inc;

  // Profile step
  logic [33:0] acc_sum, acc_sub;
  logic        acc_hit;
  logic [32:0] acc_next;
  logic [32:0] up_sum;
  logic [31:0] up_rate, dn_rate, dn_raw;
  logic [31:0] prof_rate;
  logic        prof_set;
  logic [32:0] prof_tick;
  logic [31:0] tri_tick;

  assign acc_sum  = {1'b0, tick_q} + {2'b00, period_q};
  assign acc_hit  = acc_sum > {2'b00, acc_tick_q};
  assign acc_sub  = acc_sum - {2'b00, acc_tick_q};
  assign acc_next = acc_hit ? acc_sub[32:0] : acc_sum[32:0];
  assign up_sum   = {1'b0, rate_q} + {3'b000, blk_delta_q};
  assign up_rate  = (up_sum >= {1'b0, blk_cruise_q}) ? blk_cruise_q : up_sum[31:0];
  assign dn_raw   = (rate_q > safe_q) ?
                    (({2'b00, blk_delta_q} > rate_q) ? 32'd0 : rate_q - {2'b00, blk_delta_q}) :
                    {1'b0, rate_q[31:1]};
  assign dn_rate  = (dn_raw < blk_end_q) ? blk_end_q : dn_raw;
  assign tri_tick = (tick_q > {1'b0, acc_tick_q}) ? 32'd0 : acc_tick_q - tick_q[31:0];

  always_comb begin
    prof_set  = 1'b0;
    prof_rate = blk_cruise_q;
    prof_tick = tick_q;
    if (ev_done_q < blk_acc_q) begin
      prof_tick = acc_next;
      prof_set  = acc_hit;
      prof_rate = up_rate;
    end else if (ev_done_q >= blk_dec_q) begin
      if (ev_done_q == blk_dec_q) begin
        prof_tick = (rate_q == blk_cruise_q) ? {2'b00, acc_tick_q[31:1]} : {1'b0, tri_tick};
      end else begin
        prof_tick = acc_next;
        prof_set  = acc_hit;
        prof_rate = dn_rate;
      end
    end else begin
      prof_set = rate_q != blk_cruise_q;
    end
  end

  // Divider operands: floored rate, clock times sixty
  logic [31:0] new_rate, floor_rate;
  assign new_rate   = cmd_i.accept ? start_rate_i : prof_rate;
  assign floor_rate = (new_rate < {12'd0, min_rate_q}) ?
                      (min_rate_q == '0 ? 32'd1 : {12'd0, min_rate_q}) :
                      (new_rate == '0 ? 32'd1 : new_rate);
  assign divisor_o  = floor_rate;
  assign dividend_o = {clk_hz_q, 6'd0} - {4'd0, clk_hz_q, 2'd0};

  assign sts_o.need_prof = (func == FUNC_TICK) && (mode_q == MODE_EXEC) && !blk_last;
  assign sts_o.need_div  = func == FUNC_LOAD;
  assign sts_o.prof_set  = prof_set;
  assign sts_o.div_done  = div_done_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q   <= CLOCK_HZ_RST;
      min_rate_q <= MIN_RATE_RST;
      acc_tick_q <= ACC_TICK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CLOCK_HZ: clk_hz_q   <= cfg_wdata_i[26:0];
        CFG_MIN_RATE: min_rate_q <= cfg_wdata_i[19:0];
        CFG_ACC_TICK: acc_tick_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      bres_q      <= '0;
      ev_done_q   <= '0;
      rate_q      <= '0;
      tick_q      <= '0;
      period_q    <= PERIOD_RST;
      safe_q      <= '0;
      pos_q       <= '0;
      pend_step_q <= 1'b0;
      pend_dir_q  <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        case (func)
          FUNC_TICK: begin
            if (pend_step_q) begin
              pos_q       <= pend_dir_q ? pos_q - 32'd1 : pos_q + 32'd1;
              pend_step_q <= 1'b0;
            end
            if (mode_q == MODE_EXEC) begin
              pend_dir_q <= blk_len_q[31];
              bres_q     <= bres_next;
              if (bres_hit) pend_step_q <= 1'b1;
              ev_done_q  <= ev_inc;
              if (blk_last) mode_q <= MODE_SYNC;
            end
          end
          FUNC_LOAD: begin
            mode_q      <= MODE_EXEC;
            rate_q      <= start_rate_i;
            tick_q      <= {2'b00, acc_tick_q[31:1]};
            safe_q      <= 32'({2'b00, rate_delta_i} + {1'b0, rate_delta_i, 1'b0}) >> 1;
            bres_q      <= 34'd0 - {4'd0, move_events_i[30:1]};
            ev_done_q   <= '0;
            pend_step_q <= 1'b0;
            pend_dir_q  <= 1'b0;
          end
          FUNC_SETPOS: pos_q <= position_value_i;
          default: ;
        endcase
      end
      if (cmd_i.prof) begin
        tick_q <= prof_tick;
        if (prof_set) rate_q <= prof_rate;
      end
      if (cmd_i.period_wr) begin
        period_q <= quotient_i[32] ? 32'hFFFF_FFFF : quotient_i[31:0];
      end
    end
  end

  // Block registers and result flags hold payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pulse_q <= 1'b0;
      dir_q   <= 1'b0;
      sync_q  <= 1'b0;
      done_q  <= 1'b0;
      load_q  <= 1'b0;
      run_q   <= (mode_q == MODE_EXEC) || (mode_q == MODE_SYNC);
      case (func)
        FUNC_TICK: begin
          pulse_q <= pend_step_q;
          dir_q   <= pend_step_q & pend_dir_q;
          sync_q  <= mode_q == MODE_SYNC;
          done_q  <= (mode_q == MODE_EXEC) && blk_last;
        end
        FUNC_LOAD: begin
          load_q       <= 1'b1;
          run_q        <= 1'b1;
          blk_len_q    <= move_length_i;
          blk_events_q <= move_events_i;
          blk_cruise_q <= cruise_rate_i;
          blk_end_q    <= end_rate_i;
          blk_delta_q  <= rate_delta_i;
          blk_acc_q    <= accel_end_mark_i;
          blk_dec_q    <= decel_start_mark_i;
        end
        default: ;
      endcase
    end
  end

  assign step_pulse_o     = pulse_q;
  assign step_dir_o       = dir_q;
  assign timer_period_o   = load_q ? LOAD_PERIOD : period_q;
  assign timer_run_o      = run_q;
  assign sync_request_o   = sync_q;
  assign block_done_o     = done_q;
  assign mode_o           = mode_q;
  assign motor_position_o = pos_q;

endmodule

>>> test/trapezoid_step_profile_generator_tb.sv
// Self-checking testbench for trapezoid_step_profile_generator.
// Needs tspg_pkg and the block's RTL. Drives directed and random move blocks and
// checks every result against a cycle-free profile predictor or a directed-table value.
module trapezoid_step_profile_generator_tb
  import tspg_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned ITEM_TARGET = 1900;

  typedef struct {
    func_e       func;
    logic [31:0] len;
    logic [30:0] events;
    logic [31:0] start_rate;
    logic [31:0] cruise_rate;
    logic [31:0] end_rate;
    logic [29:0] delta;
    logic [30:0] acc_end;
    logic [30:0] dec_start;
    logic [31:0] pos_value;
  } motion_item_t;

  typedef struct {
    logic        pulse;
    logic        dir;
    logic [31:0] period;
    logic        run;
    logic        sync;
    logic        done;
    logic [1:0]  mode;
    logic [31:0] pos;
  } step_result_t;

  typedef struct {
    motion_item_t item;
    logic         typed;
    step_result_t res;
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i = '0;
  logic [31:0] move_length_i = '0;
  logic [30:0] move_events_i = '0;
  logic [31:0] start_rate_i = '0;
  logic [31:0] cruise_rate_i = '0;
  logic [31:0] end_rate_i = '0;
  logic [29:0] rate_delta_i = '0;
  logic [30:0] accel_end_mark_i = '0;
  logic [30:0] decel_start_mark_i = '0;
  logic [31:0] position_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic        step_pulse_o;
  logic        step_dir_o;
  logic [31:0] timer_period_o;
  logic        timer_run_o;
  logic        sync_request_o;
  logic        block_done_o;
  logic [1:0]  mode_o;
  logic [31:0] motor_position_o;

  trapezoid_step_profile_generator dut (.*);

  // Predictor state and its copy of the configuration registers.
  logic [26:0] cfg_clock_hz;
  logic [19:0] cfg_min_rate;
  logic [31:0] cfg_acc_tick;
  mode_e       pm_mode;
  logic [33:0] pm_bres;
  logic [30:0] pm_events_done;
  logic [31:0] pm_rate;
  logic [32:0] pm_accum;
  logic [31:0] pm_period;
  logic [31:0] pm_safe;
  logic [31:0] pm_pos;
  logic        pm_pend_step;
  logic        pm_pend_dir;
  logic [31:0] blk_len;
  logic [30:0] blk_events;
  logic [31:0] blk_cruise;
  logic [31:0] blk_end;
  logic [29:0] blk_delta;
  logic [30:0] blk_acc_end;
  logic [30:0] blk_dec_start;

  step_result_t expected_results[$];
  int unsigned  error_count = 0;
  int unsigned  items_sent = 0;
  int unsigned  results_seen = 0;
  int unsigned  loads_sent = 0;
  int unsigned  burst_left = 0;
  bit           hold_request = 1'b0;

  function automatic logic [31:0] period_for_rate(logic [31:0] rate);
    logic [63:0] r;
    logic [63:0] q;
    r = (rate < {12'd0, cfg_min_rate}) ? {44'd0, cfg_min_rate} : {32'd0, rate};
    if (r == 0) r = 1;
    q = ({37'd0, cfg_clock_hz} * 64'd60) / r;
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  task automatic apply_rate(logic [31:0] rate);
    pm_rate   = rate;
    pm_period = period_for_rate(rate);
  endtask

  // Advance the acceleration tick accumulator; return 1 on a tick boundary.
  function automatic bit accel_boundary();
    logic [63:0] a;
    bit hit;
    a = {31'd0, pm_accum} + {32'd0, pm_period};
    hit = a > {32'd0, cfg_acc_tick};
    if (hit) a = a - {32'd0, cfg_acc_tick};
    pm_accum = a[32:0];
    return hit;
  endfunction

  task automatic advance_profile();
    logic [63:0] sum;
    logic [31:0] r;
    if (pm_events_done < blk_acc_end) begin
      if (accel_boundary()) begin
        sum = {32'd0, pm_rate} + {34'd0, blk_delta};
        apply_rate((sum >= {32'd0, blk_cruise}) ? blk_cruise : sum[31:0]);
      end
    end else if (pm_events_done >= blk_dec_start) begin
      if (pm_events_done == blk_dec_start) begin
        // Start of deceleration: mirror the accumulator for a triangle move.
        if (pm_rate == blk_cruise) pm_accum = {1'b0, cfg_acc_tick >> 1};
        else if (pm_accum > {1'b0, cfg_acc_tick}) pm_accum = '0;
        else pm_accum = {1'b0, cfg_acc_tick} - pm_accum;
      end else if (accel_boundary()) begin
        r = pm_rate;
        // Halve below the safe rate so the rate never jumps past zero.
        if (r > pm_safe) r = ({2'd0, blk_delta} > r) ? 32'd0 : r - {2'd0, blk_delta};
        else r = r >> 1;
        if (r < blk_end) r = blk_end;
        apply_rate(r);
      end
    end else if (pm_rate != blk_cruise) begin
      apply_rate(blk_cruise);
    end
  endtask

  task automatic predict_step(input motion_item_t it, output step_result_t res);
    logic [33:0] mag;
    logic [31:0] neg;
    res = '{pulse: 1'b0, dir: 1'b0, period: pm_period, run: 1'b0, sync: 1'b0,
            done: 1'b0, mode: 2'd0, pos: 32'd0};
    case (it.func)
      FUNC_TICK: begin
        if (pm_pend_step) begin
          res.pulse = 1'b1;
          res.dir = pm_pend_dir;
          pm_pos = pm_pend_dir ? pm_pos - 32'd1 : pm_pos + 32'd1;
          pm_pend_step = 1'b0;
        end
        if (pm_mode == MODE_EXEC) begin
          res.run = 1'b1;
          pm_pend_dir = blk_len[31];
          if (blk_len[31]) begin
            neg = ~blk_len + 32'd1;
            mag = (neg == 0) ? 34'h0_8000_0000 : {2'd0, neg};
          end else begin
            mag = {2'd0, blk_len};
          end
          pm_bres = pm_bres + mag;
          if (pm_bres != 0 && !pm_bres[33]) begin
            pm_pend_step = 1'b1;
            pm_bres = pm_bres - {3'd0, blk_events};
          end
          pm_events_done = pm_events_done + 31'd1;
          if (blk_events <= pm_events_done) begin
            pm_mode = MODE_SYNC;
            res.done = 1'b1;
          end else begin
            advance_profile();
          end
          res.period = pm_period;
        end else if (pm_mode == MODE_SYNC) begin
          res.run = 1'b1;
          res.sync = 1'b1;
        end
      end
      FUNC_LOAD: begin
        blk_len = it.len;
        blk_events = it.events;
        blk_cruise = it.cruise_rate;
        blk_end = it.end_rate;
        blk_delta = it.delta;
        blk_acc_end = it.acc_end;
        blk_dec_start = it.dec_start;
        pm_mode = MODE_EXEC;
        apply_rate(it.start_rate);
        pm_accum = {1'b0, cfg_acc_tick >> 1};
        pm_safe = (32'd3 * {2'd0, it.delta}) >> 1;
        pm_bres = 34'd0 - {4'd0, it.events[30:1]};
        pm_events_done = '0;
        pm_pend_step = 1'b0;
        pm_pend_dir = 1'b0;
        res.period = LOAD_PERIOD;
        res.run = 1'b1;
      end
      default: begin
        if (it.func == FUNC_SETPOS) pm_pos = it.pos_value;
        res.run = (pm_mode == MODE_EXEC || pm_mode == MODE_SYNC);
      end
    endcase
    res.mode = pm_mode;
    res.pos = pm_pos;
  endtask

  task automatic report(string field, logic [31:0] want, logic [31:0] got);
    error_count++;
    $display("MISMATCH result %0d %s: expected %h got %h", results_seen, field, want, got);
  endtask

  // Clock and cycle limit.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  int unsigned cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("trapezoid_step_profile_generator_tb failed");
      $finish;
    end
  end

  // Receiver: stall on a changing duty pattern, or hold off for a long stretch
  // when asked so that the block backs up into its input.
  initial begin
    int unsigned pct;
    int unsigned phase_left;
    int unsigned hold_left;
    pct = 0;
    phase_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request && hold_left == 0) begin
        hold_left = 400;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i = 1'b1;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(16, 96);
          case ($urandom_range(0, 4))
            0, 1: pct = 0;
            2: pct = 25;
            3: pct = 50;
            default: pct = 90;
          endcase
        end
        phase_left--;
        out_stall_i = ($urandom_range(0, 99) < pct);
      end
    end
  end

  // Monitor: compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    step_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report("result with no expectation waiting", 32'd0, 32'd1);
      end else begin
        want = expected_results.pop_front();
        if (step_pulse_o !== want.pulse) report("step_pulse", want.pulse, step_pulse_o);
        if (step_dir_o !== want.dir) report("step_dir", want.dir, step_dir_o);
        if (timer_period_o !== want.period) report("timer_period", want.period, timer_period_o);
        if (timer_run_o !== want.run) report("timer_run", want.run, timer_run_o);
        if (sync_request_o !== want.sync) report("sync_request", want.sync, sync_request_o);
        if (block_done_o !== want.done) report("block_done", want.done, block_done_o);
        if (mode_o !== want.mode) report("mode", want.mode, mode_o);
        if (motor_position_o !== want.pos) report("motor_position", want.pos, motor_position_o);
      end
      results_seen++;
    end
  end

  // Send one transaction; typed expectations replace the predicted one but the
  // predictor still advances.
  task automatic send_item(motion_item_t it, bit typed, step_result_t typed_res);
    step_result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    func_i = it.func;
    move_length_i = it.len;
    move_events_i = it.events;
    start_rate_i = it.start_rate;
    cruise_rate_i = it.cruise_rate;
    end_rate_i = it.end_rate;
    rate_delta_i = it.delta;
    accel_end_mark_i = it.acc_end;
    decel_start_mark_i = it.dec_start;
    position_value_i = it.pos_value;
    do @(posedge clk_i); while (in_stall_o);
    predict_step(it, res);
    expected_results.push_back(typed ? typed_res : res);
    items_sent++;
    if (it.func == FUNC_LOAD) loads_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (expected_results.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write one register while the block is idle.
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_CLOCK_HZ: cfg_clock_hz = data[26:0];
      CFG_MIN_RATE: cfg_min_rate = data[19:0];
      CFG_ACC_TICK: cfg_acc_tick = data;
      default: ;
    endcase
  endtask

  function automatic motion_item_t plain(func_e f);
    motion_item_t it;
    it = '{func: f, len: '0, events: '0, start_rate: '0, cruise_rate: '0, end_rate: '0,
           delta: '0, acc_end: '0, dec_start: '0, pos_value: '0};
    return it;
  endfunction

  function automatic motion_item_t load_item(logic [31:0] len, logic [30:0] ev,
      logic [31:0] sr, logic [31:0] cr, logic [31:0] er, logic [29:0] dl,
      logic [30:0] ae, logic [30:0] ds);
    motion_item_t it;
    it = plain(FUNC_LOAD);
    it.len = len; it.events = ev; it.start_rate = sr; it.cruise_rate = cr;
    it.end_rate = er; it.delta = dl; it.acc_end = ae; it.dec_start = ds;
    return it;
  endfunction

  function automatic motion_item_t noise_item();
    motion_item_t it;
    it.func = func_e'($urandom_range(0, 3));
    it.len = $urandom(); it.events = $urandom(); it.start_rate = $urandom();
    it.cruise_rate = $urandom(); it.end_rate = $urandom(); it.delta = $urandom();
    it.acc_end = $urandom(); it.dec_start = $urandom(); it.pos_value = $urandom();
    // Keep noise loads short so they do not swallow the random budget.
    if (it.func == FUNC_LOAD && $urandom_range(0, 3) != 0) it.events = $urandom_range(0, 8);
    return it;
  endfunction

  // One move: a load, then for a narrow move its ticks and a few extra in sync, for a wide
  // one up to twenty ticks, with stray position writes in place of ticks now and then.
  task automatic send_move(bit wide);
    motion_item_t it;
    step_result_t none;
    logic [30:0] ev;
    logic [31:0] sr, cr, er, mag;
    int unsigned ticks;
    none = '{default: '0};
    ev = wide ? 31'($urandom()) : 31'($urandom_range(0, 30));
    mag = wide ? $urandom() : $urandom_range(0, ev);
    sr = $urandom_range(0, 20000);
    cr = sr + $urandom_range(0, 60000);
    er = $urandom_range(0, cr);
    if ($urandom_range(0, 7) == 0) begin
      sr = $urandom(); cr = $urandom(); er = $urandom();
    end
    it = load_item($urandom_range(0, 1) ? -mag : mag, ev, sr, cr, er,
                   ($urandom_range(0, 9) == 0) ? 30'($urandom()) : 30'($urandom_range(0, 8000)),
                   31'($urandom_range(0, ev)), 31'($urandom_range(0, ev)));
    if (it.acc_end > it.dec_start && $urandom_range(0, 1)) it.dec_start = it.acc_end;
    send_item(it, 1'b0, none);
    ticks = wide ? $urandom_range(1, 20) : ev + $urandom_range(0, 3);
    repeat (ticks) begin
      if ($urandom_range(0, 15) == 0) begin
        it = plain(FUNC_SETPOS);
        it.pos_value = $urandom();
      end else begin
        it = plain(FUNC_TICK);
      end
      send_item(it, 1'b0, none);
    end
  endtask

  directed_row_t directed[$];

  task automatic add_row(motion_item_t it, bit typed, step_result_t res);
    directed_row_t row;
    row.item = it;
    row.typed = typed;
    row.res = res;
    directed.push_back(row);
  endtask

  initial begin
    step_result_t none;
    step_result_t r;
    motion_item_t it;
    int unsigned target;
    none = '{default: '0};
    cfg_clock_hz = CLOCK_HZ_RST;
    cfg_min_rate = MIN_RATE_RST;
    cfg_acc_tick = ACC_TICK_RST;
    pm_mode = MODE_IDLE;
    pm_bres = '0; pm_events_done = '0; pm_rate = '0; pm_accum = '0; pm_safe = '0;
    pm_pos = '0; pm_pend_step = 1'b0; pm_pend_dir = 1'b0;
    pm_period = period_for_rate(32'd0);
    {blk_len, blk_events, blk_cruise, blk_end, blk_delta, blk_acc_end, blk_dec_start} = '0;

    // Directed table: idle status, position extremes, loads at the field
    // extremes, a zero-event block, and deceleration starting at cruise.
    r = '{pulse: 0, dir: 0, period: PERIOD_RST, run: 0, sync: 0, done: 0,
          mode: MODE_IDLE, pos: 32'd0};
    add_row(plain(FUNC_TICK), 1'b1, r);
    it = plain(FUNC_SETPOS); it.pos_value = 32'h7FFF_FFFF;
    r.pos = 32'h7FFF_FFFF;
    add_row(it, 1'b1, r);
    add_row(plain(FUNC_NOP), 1'b1, r);
    it.pos_value = 32'h8000_0000;
    r.pos = 32'h8000_0000;
    add_row(it, 1'b1, r);
    r.period = LOAD_PERIOD; r.run = 1; r.mode = MODE_EXEC;
    add_row(load_item(-32'sd3, 31'd4, 32'd1000, 32'd5000, 32'd500, 30'd2000, 31'd1, 31'd3),
            1'b1, r);
    repeat (6) add_row(plain(FUNC_TICK), 1'b0, none);
    // The backward block above issues three pulses before it settles in sync.
    r.pos = 32'h7FFF_FFFD;
    add_row(load_item(32'h8000_0000, 31'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      30'h3FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF), 1'b1, r);
    repeat (3) add_row(plain(FUNC_TICK), 1'b0, none);
    add_row(load_item(32'h7FFF_FFFF, 31'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 30'd0, 31'd0,
                      31'd0), 1'b0, none);
    repeat (2) add_row(plain(FUNC_TICK), 1'b0, none);
    add_row(load_item(32'd5, 31'd6, 32'd3000, 32'd3000, 32'd100, 30'd1500, 31'd0, 31'd0),
            1'b0, none);
    repeat (6) add_row(plain(FUNC_TICK), 1'b0, none);

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) send_item(directed[i].item, directed[i].typed, directed[i].res);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      // Settings: reset values, then both extremes, then a random mix.
      case (phase)
        1: begin
          write_reg(CFG_CLOCK_HZ, 32'd71582788);
          write_reg(CFG_MIN_RATE, 32'd1);
          write_reg(CFG_ACC_TICK, 32'd1);
        end
        2: begin
          write_reg(CFG_CLOCK_HZ, 32'd1000000);
          write_reg(CFG_MIN_RATE, 32'd1000000);
          write_reg(CFG_ACC_TICK, 32'hFFFF_FFFF);
        end
        3: begin
          write_reg(CFG_CLOCK_HZ, $urandom_range(1000000, 71582788));
          write_reg(CFG_MIN_RATE, $urandom_range(1, 1000000));
          write_reg(CFG_ACC_TICK, $urandom_range(1, 2000000));
        end
        default: ;
      endcase

      // Back the block up: the receiver holds off while one move's items keep coming.
      hold_request = 1'b1;
      send_move(1'b0);
      drain();

      target = items_sent + ITEM_TARGET / 4;
      while (items_sent < target) begin
        case ($urandom_range(0, 9))
          0, 1: send_item(noise_item(), 1'b0, none);
          2: send_move(1'b1);
          default: send_move(1'b0);
        endcase
      end
      drain();
    end

    $display("covered %0d transactions, %0d move loads, over four register settings",
             items_sent, loads_sent);
    $display("results checked: %0d, mismatches: %0d", results_seen, error_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("trapezoid_step_profile_generator_tb passed");
    end else begin
      $display("trapezoid_step_profile_generator_tb failed");
    end
    $finish;
  end

endmodule
